/* design/girb_pkg.sv */
// ----------------------------------------------------------------------------
// girb_pkg
// Shared types and constants of the grayscale image rectangle blend block.
// ----------------------------------------------------------------------------
`default_nettype none

package girb_pkg;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 8;
	localparam int OUT_USER_W = 1;
	localparam int CFG_W      = 7;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam logic [CFG_W-1:0] CFG_MIN   = 7'd4;

	typedef enum logic [1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_BLEND = 2'd2,
		FN_FILL  = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PIX_WR,
		ST_PIX_RD,
		ST_RD_WAIT,
		ST_BL_RD,
		ST_BL_WR,
		ST_FILL
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic init;
		logic mem_re;
		logic mem_we;
		logic blend;
		logic fill_step;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  bad;
		logic  col_last;
		logic  row_last;
		logic  fill_last;
		logic  out_free;
	} sts_t;

endpackage

`default_nettype wire

/* design/girb_ctrl.sv */
// ----------------------------------------------------------------------------
// girb_ctrl
// Request sequencer: checks bounds, then walks pixel, blend or fill steps.
// ----------------------------------------------------------------------------
`default_nettype none

module girb_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire girb_pkg::sts_t sts,
	output girb_pkg::cmd_t     cmd
);
	import girb_pkg::*;

	typedef enum logic {
		PH_WORK,
		PH_DONE
	} phase_t;

	state_t state_q;
	state_t state_nxt;
	phase_t phase_q;
	phase_t phase_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_WORK;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		phase_nxt = phase_q;
		cmd       = '0;
		if (phase_q == PH_DONE) begin
			if (sts.out_free) begin
				cmd.out_load = 1'b1;
				phase_nxt    = PH_WORK;
				state_nxt    = ST_IDLE;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmd.in_ready = 1'b1;
					if (s_tvalid) begin
						cmd.load  = 1'b1;
						state_nxt = ST_CHECK;
					end
				end
				ST_CHECK: begin
					cmd.init = 1'b1;
					if (sts.bad) begin
						phase_nxt = PH_DONE;
					end else begin
						case (sts.func)
							FN_WRITE: state_nxt = ST_PIX_WR;
							FN_READ:  state_nxt = ST_PIX_RD;
							FN_BLEND: state_nxt = ST_BL_RD;
							FN_FILL:  state_nxt = ST_FILL;
							default:  state_nxt = ST_IDLE;
						endcase
					end
				end
				ST_PIX_WR: begin
					cmd.mem_we = 1'b1;
					phase_nxt  = PH_DONE;
				end
				ST_PIX_RD: begin
					cmd.mem_re = 1'b1;
					state_nxt  = ST_RD_WAIT;
				end
				ST_RD_WAIT: begin
					phase_nxt = PH_DONE;
				end
				ST_BL_RD: begin
					cmd.mem_re = 1'b1;
					state_nxt  = ST_BL_WR;
				end
				ST_BL_WR: begin
					cmd.mem_we = 1'b1;
					cmd.blend  = 1'b1;
					cmd.step   = 1'b1;
					if (sts.col_last && sts.row_last) begin
						phase_nxt = PH_DONE;
					end else begin
						state_nxt = ST_BL_RD;
					end
				end
				ST_FILL: begin
					cmd.mem_we    = 1'b1;
					cmd.fill_step = 1'b1;
					if (sts.fill_last) begin
						phase_nxt = PH_DONE;
					end
				end
				default: begin
					state_nxt = ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/girb_dp.sv */
// ----------------------------------------------------------------------------
// girb_dp
// Datapath: request registers, address walk, pixel memory and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module girb_dp #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire girb_pkg::cmd_t                  cmd,
	output girb_pkg::sts_t                       sts,
	input  wire logic [girb_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic [girb_pkg::IN_USER_W-1:0]  s_tuser,
	input  wire logic                            m_tready,
	output logic                                 m_tvalid,
	output logic [girb_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [girb_pkg::OUT_USER_W-1:0]      m_tuser,
	input  wire logic                            cfg_wr_en,
	input  wire logic [girb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [girb_pkg::CFG_W-1:0]      cfg_wdata
);
	import girb_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int WMAX  = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int HMAX  = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	logic [CFG_W-1:0] cfg_w_q;
	logic [CFG_W-1:0] cfg_h_q;
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;

	func_t      func_q;
	logic [5:0] x_q;
	logic [5:0] y_q;
	logic [6:0] rw_q;
	logic [6:0] rh_q;
	logic [7:0] val_q;
	logic       bad_q;

	logic [6:0]    col_q;
	logic [6:0]    row_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] fill_cnt_q;
	logic [AW-1:0] addr;
	logic [13:0]   prod;
	logic [7:0]    x_end;
	logic [7:0]    y_end;
	logic          bad;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;
	logic [8:0] avg_sum;
	logic [7:0] wdata;

	logic       out_valid_q;
	logic [7:0] out_rd_q;
	logic       out_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_RESET;
			cfg_h_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_WIDTH:  cfg_w_q <= cfg_wdata;
				REG_HEIGHT: cfg_h_q <= cfg_wdata;
				default:    cfg_w_q <= cfg_w_q;
			endcase
		end
	end

	always_comb begin
		if (cfg_w_q < CFG_MIN) begin
			w_eff = CFG_MIN;
		end else if (cfg_w_q > CFG_W'(WMAX)) begin
			w_eff = CFG_W'(WMAX);
		end else begin
			w_eff = cfg_w_q;
		end
		if (cfg_h_q < CFG_MIN) begin
			h_eff = CFG_MIN;
		end else if (cfg_h_q > CFG_W'(HMAX)) begin
			h_eff = CFG_W'(HMAX);
		end else begin
			h_eff = cfg_h_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(s_tuser);
			x_q    <= s_tdata[5:0];
			y_q    <= s_tdata[11:6];
			rw_q   <= s_tdata[18:12];
			rh_q   <= s_tdata[25:19];
			val_q  <= s_tdata[33:26];
		end
	end

	assign x_end = 8'(x_q) + 8'(rw_q);
	assign y_end = 8'(y_q) + 8'(rh_q);

	always_comb begin
		case (func_q)
			FN_WRITE, FN_READ: bad = !((7'(x_q) < w_eff) && (7'(y_q) < h_eff));
			FN_BLEND: bad = (rw_q == 7'd0) || (rh_q == 7'd0) ||
				(x_end > 8'(w_eff)) || (y_end > 8'(h_eff));
			FN_FILL:  bad = 1'b0;
			default:  bad = 1'b1;
		endcase
	end

	assign prod = 14'(y_q) * 14'(w_eff);

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			bad_q      <= bad;
			col_q      <= 7'(x_q);
			row_q      <= 7'(y_q);
			base_q     <= AW'(prod);
			fill_cnt_q <= '0;
		end else begin
			if (cmd.step) begin
				if (sts.col_last) begin
					col_q  <= 7'(x_q);
					row_q  <= row_q + 7'd1;
					base_q <= base_q + AW'(w_eff);
				end else begin
					col_q <= col_q + 7'd1;
				end
			end
			if (cmd.fill_step) begin
				fill_cnt_q <= fill_cnt_q + AW'(1);
			end
		end
	end

	assign addr    = cmd.fill_step ? fill_cnt_q : (base_q + AW'(col_q));
	assign avg_sum = 9'(rd_q) + 9'(val_q);
	assign wdata   = cmd.blend ? avg_sum[8:1] : val_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[addr] <= wdata;
		end
		if (cmd.mem_re) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_rd_q <= (func_q == FN_READ && !bad_q) ? rd_q : 8'd0;
			out_st_q <= bad_q;
		end
	end

	assign sts.func      = func_q;
	assign sts.bad       = bad;
	assign sts.col_last  = (8'(col_q) + 8'd1) == x_end;
	assign sts.row_last  = (8'(row_q) + 8'd1) == y_end;
	assign sts.fill_last = fill_cnt_q == LAST_ADDR;
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_rd_q;
	assign m_tuser  = out_st_q;

endmodule

`default_nettype wire

/* design/gray_image_rectangle_blend.sv */
// ----------------------------------------------------------------------------
// gray_image_rectangle_blend
// Grayscale image store with pixel write, pixel read, fill and rectangle blend.
// ----------------------------------------------------------------------------
// A request is loaded and checked against the image size; a rejected request
// goes straight to the result, any other first walks its memory steps.
// One request is worked at a time; the single pixel memory port sets the rate:
// each blended pixel is read, then written back; a fill writes the whole store.
// A new request is taken while the previous result waits in the output register.
// Reset clears the sequencer and the output valid flag and sets both size
// registers to 64; the image contents are undefined until written.
`default_nettype none

module gray_image_rectangle_blend #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// x[5:0], y[11:6], rect_width[18:12], rect_height[25:19], value[33:26]
	input  wire logic [girb_pkg::IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  wire logic [girb_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// read_value[7:0]
	output logic [girb_pkg::OUT_DATA_W-1:0]      m_tdata,
	// status[0]
	output logic [girb_pkg::OUT_USER_W-1:0]      m_tuser,
	input  wire logic                            cfg_wr_en,
	input  wire logic [girb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [girb_pkg::CFG_W-1:0]      cfg_wdata
);
	import girb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	girb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	girb_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	assign s_tready = cmd.in_ready;

endmodule

`default_nettype wire

/* design/girb_checker.sv */
// ----------------------------------------------------------------------------
// girb_checker
// Port-level checks of the grayscale image rectangle blend block.
// ----------------------------------------------------------------------------
`default_nettype none

module girb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [0:0] m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result changed while stalled.");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
		else $error("Rejected request returned a nonzero pixel.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Request taken while another is in progress.");

	a_no_result_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("Result appeared one cycle after a request.");

endmodule

bind gray_image_rectangle_blend girb_checker u_girb_checker (.*);

`default_nettype wire

/* verif/image_result_checker.sv */
// ----------------------------------------------------------------------------
// image_result_checker
// Watches the request, result and register channels of the grayscale image
// block, keeps its own copy of the image and the size registers, predicts
// the answer to every accepted request and compares each result with the
// oldest prediction. Handshakes are sampled on the falling clock edge, when
// every signal that the next rising edge will act on is stable.
// ----------------------------------------------------------------------------
module image_result_checker
	import girb_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata,
	output int                    fail_count,
	output int                    pending_count
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;

	typedef struct packed {
		logic [7:0] read_value;
		logic       status;
	} answer_t;

	logic [7:0]  image_copy [0:PIXELS-1];
	int unsigned img_w;
	int unsigned img_h;
	answer_t     pending_answers [$];
	int          fails = 0;
	int          waiting = 0;

	assign fail_count    = fails;
	assign pending_count = waiting;

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
		if (v < CFG_MIN) begin
			return CFG_MIN;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	initial begin
		img_w = clamp_size(CFG_RESET, MAX_WIDTH);
		img_h = clamp_size(CFG_RESET, MAX_HEIGHT);
	end

	function automatic answer_t apply_request(input func_t f, input logic [5:0] x,
			input logic [5:0] y, input logic [6:0] rw, input logic [6:0] rh,
			input logic [7:0] v);
		answer_t    ans;
		int         addr;
		logic [8:0] sum;
		ans = '0;
		case (f)
			FN_WRITE: begin
				if (x < img_w && y < img_h) begin
					image_copy[y * img_w + x] = v;
				end else begin
					ans.status = 1'b1;
				end
			end
			FN_READ: begin
				if (x < img_w && y < img_h) begin
					ans.read_value = image_copy[y * img_w + x];
				end else begin
					ans.status = 1'b1;
				end
			end
			FN_BLEND: begin
				if (rw == 0 || rh == 0 || x + rw > img_w || y + rh > img_h) begin
					ans.status = 1'b1;
				end else begin
					for (int r = y; r < y + rh; r++) begin
						for (int c = x; c < x + rw; c++) begin
							addr = r * img_w + c;
							sum = image_copy[addr] + v;
							image_copy[addr] = sum[8:1];
						end
					end
				end
			end
			default: begin
				for (int i = 0; i < PIXELS; i++) begin
					image_copy[i] = v;
				end
			end
		endcase
		return ans;
	endfunction

	always @(negedge clk) begin : watch
		answer_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_WIDTH:  img_w = clamp_size(cfg_wdata, MAX_WIDTH);
					REG_HEIGHT: img_h = clamp_size(cfg_wdata, MAX_HEIGHT);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				pending_answers.push_back(apply_request(func_t'(s_tuser), s_tdata[5:0],
					s_tdata[11:6], s_tdata[18:12], s_tdata[25:19], s_tdata[33:26]));
			end
			if (m_tvalid && m_tready) begin
				if (pending_answers.size() == 0) begin
					$error("Result with no request waiting: read_value %0d, status %0d",
						m_tdata, m_tuser);
					fails++;
				end else begin
					want = pending_answers.pop_front();
					if (m_tdata[7:0] !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value, m_tdata);
						fails++;
					end
					if (m_tuser[0] !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser[0]);
						fails++;
					end
				end
			end
			waiting = pending_answers.size();
		end
	end

endmodule

/* verif/gray_image_rectangle_blend_test.sv */
// ----------------------------------------------------------------------------
// gray_image_rectangle_blend_test
// Drives pixel writes, reads, fills and rectangle blends into the image block
// over several image sizes, including sizes outside the legal range, with
// random idle bursts on both channels and one long result stall. The image
// is filled first, so no pixel is ever read before it has been written.
// ----------------------------------------------------------------------------
module gray_image_rectangle_blend_test;

	timeunit 1ns;
	timeprecision 1ps;

	import girb_pkg::*;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE_CYCLES = 64;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	int   fail_count;
	int   pending_count;
	int   cycle_count = 0;
	bit   calm = 1'b0;
	bit   long_hold_req = 1'b0;
	bit   long_hold_done = 1'b0;
	int unsigned cur_w = MAX_WIDTH;
	int unsigned cur_h = MAX_HEIGHT;

	always #2 clk = ~clk;

	gray_image_rectangle_blend #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	image_result_checker #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	function automatic int unsigned effective_size(input logic [CFG_W-1:0] v,
			input int unsigned maxv);
		if (v < CFG_MIN) begin
			return CFG_MIN;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	task automatic offer_request(input func_t f, input logic [5:0] x, input logic [5:0] y,
			input logic [6:0] rw, input logic [6:0] rh, input logic [7:0] v);
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {6'd0, v, rh, rw, y, x};
		@(negedge clk);
		while (!s_tready) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_count != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_image_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_index <= REG_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_w = effective_size(w, MAX_WIDTH);
		cur_h = effective_size(h, MAX_HEIGHT);
	endtask

	task automatic send_random_requests(input int count);
		func_t       f;
		logic [5:0]  x;
		logic [5:0]  y;
		logic [6:0]  rw;
		logic [6:0]  rh;
		logic [7:0]  v;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			v  = 8'($urandom_range(0, 255));
			x  = 6'($urandom_range(0, 63));
			y  = 6'($urandom_range(0, 63));
			rw = 7'($urandom_range(0, 127));
			rh = 7'($urandom_range(0, 127));
			if (pick < 8) begin
				f = func_t'($urandom_range(0, 3));
			end else if (pick < 10) begin
				f = FN_FILL;
			end else if (pick < 70) begin
				f = (pick < 40) ? FN_WRITE : FN_READ;
				if ($urandom_range(0, 9) != 0) begin
					x = 6'($urandom_range(0, cur_w - 1));
					y = 6'($urandom_range(0, cur_h - 1));
				end
			end else begin
				f = FN_BLEND;
				if ($urandom_range(0, 24) == 0) begin
					rw = 7'($urandom_range(1, cur_w));
					rh = 7'($urandom_range(1, cur_h));
				end else begin
					rw = 7'($urandom_range(1, (cur_w < 8) ? cur_w : 8));
					rh = 7'($urandom_range(1, (cur_h < 8) ? cur_h : 8));
				end
				x = 6'($urandom_range(0, cur_w - rw));
				y = 6'($urandom_range(0, cur_h - rh));
			end
			offer_request(f, x, y, rw, rh, v);
			if (!calm && $urandom_range(0, 3) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 14)) begin
					@(posedge clk);
				end
			end
		end
	endtask

	initial begin : result_sink
		int stall;
		forever begin
			@(posedge clk);
			stall = 0;
			if (long_hold_req && !long_hold_done) begin
				stall = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) begin
					@(posedge clk);
				end
			end
			m_tready <= 1'b1;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		repeat (7) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;

		// The whole store is filled first so that every later read is defined.
		offer_request(FN_FILL,  6'd0,  6'd0,  7'd0,   7'd0,   8'hA5);
		offer_request(FN_READ,  6'd0,  6'd0,  7'd0,   7'd0,   8'h00);
		offer_request(FN_WRITE, 6'd63, 6'd63, 7'd0,   7'd0,   8'hFF);
		offer_request(FN_READ,  6'd63, 6'd63, 7'd127, 7'd127, 8'hFF);
		offer_request(FN_WRITE, 6'd0,  6'd0,  7'd0,   7'd0,   8'h00);
		offer_request(FN_READ,  6'd0,  6'd0,  7'd0,   7'd0,   8'h00);
		offer_request(FN_BLEND, 6'd0,  6'd0,  7'd64,  7'd64,  8'hFF);
		offer_request(FN_READ,  6'd63, 6'd63, 7'd0,   7'd0,   8'h00);
		offer_request(FN_READ,  6'd0,  6'd0,  7'd0,   7'd0,   8'h00);
		offer_request(FN_BLEND, 6'd63, 6'd63, 7'd1,   7'd1,   8'h00);
		offer_request(FN_READ,  6'd63, 6'd63, 7'd0,   7'd0,   8'h00);
		offer_request(FN_BLEND, 6'd60, 6'd0,  7'd5,   7'd1,   8'h11);
		offer_request(FN_BLEND, 6'd0,  6'd60, 7'd1,   7'd5,   8'h22);
		offer_request(FN_BLEND, 6'd0,  6'd0,  7'd0,   7'd4,   8'h33);
		offer_request(FN_BLEND, 6'd0,  6'd0,  7'd4,   7'd0,   8'h44);
		offer_request(FN_BLEND, 6'd0,  6'd0,  7'd127, 7'd127, 8'h55);
		offer_request(FN_FILL,  6'd63, 6'd63, 7'd127, 7'd127, 8'h00);
		offer_request(FN_READ,  6'd31, 6'd31, 7'd0,   7'd0,   8'h00);

		// The result side stalls for a long stretch while reads keep coming.
		long_hold_req = 1'b1;
		repeat (24) begin
			offer_request(FN_READ, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
				7'd0, 7'd0, 8'h00);
		end
		send_random_requests(150);

		drain_results();
		set_image_size(7'd4, 7'd4);
		offer_request(FN_WRITE, 6'd4,  6'd0,  7'd0, 7'd0, 8'h12);
		offer_request(FN_READ,  6'd0,  6'd4,  7'd0, 7'd0, 8'h00);
		offer_request(FN_READ,  6'd63, 6'd63, 7'd0, 7'd0, 8'h00);
		offer_request(FN_WRITE, 6'd3,  6'd3,  7'd0, 7'd0, 8'h80);
		offer_request(FN_READ,  6'd3,  6'd3,  7'd0, 7'd0, 8'h00);
		offer_request(FN_BLEND, 6'd3,  6'd3,  7'd1, 7'd1, 8'h01);
		offer_request(FN_BLEND, 6'd3,  6'd0,  7'd2, 7'd1, 8'h02);
		offer_request(FN_BLEND, 6'd0,  6'd0,  7'd4, 7'd4, 8'hFF);
		send_random_requests(150);

		drain_results();
		set_image_size(7'd0, 7'd127);
		send_random_requests(150);

		drain_results();
		set_image_size(7'd127, 7'd3);
		send_random_requests(150);

		drain_results();
		set_image_size(7'd64, 7'd64);
		send_random_requests(95);

		drain_results();
		set_image_size(7'd23, 7'd41);
		send_random_requests(175);

		drain_results();
		calm = 1'b1;
		set_image_size(7'd65, 7'd64);
		send_random_requests(250);

		drain_results();
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
		if (fail_count == 0 && pending_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
